### rtl/wlfe_pkg.sv
// Shared types and constants for the wheel link frame endpoint.
// No dependencies; the front, queue, back and top-level files import this package.
`default_nettype none
package wlfe_pkg;

  localparam int unsigned FRAME_LEN = 18;
  localparam int unsigned POS_W     = 5;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  localparam int unsigned CMD_IDX_W = 3;
  localparam logic [CMD_IDX_W-1:0] CMD_IDX_LAST = 3'd7;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // input actions
  localparam logic ACT_RX  = 1'b0;
  localparam logic ACT_CMD = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_STOP      = 2'd0;
  localparam logic [1:0] REG_OPERATION = 2'd1;
  localparam logic [1:0] REG_DEVICE    = 2'd2;
  localparam logic [1:0] REG_MAX_SPEED = 2'd3;

  typedef struct packed {
    logic [7:0]  stop_code;
    logic [7:0]  operation_code;
    logic [7:0]  device_setting;
    logic [14:0] max_speed;
  } cfg_t;

  // queue entry: a report carries the decoded or latched values, a command carries the
  // clamped speeds in left/right
  typedef struct packed {
    logic               kind;
    logic               checksum_ok;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] voltage;
    logic signed [15:0] current;
    logic [7:0]         capacity;
  } entry_t;

endpackage
`default_nettype wire

### rtl/wlfe_in_if.sv
// Input channel of the wheel link frame endpoint: valid/ready plus payload.
// Standalone interface, no dependencies.
`default_nettype none
interface wlfe_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         rx_byte;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;

  modport source (output valid, action, rx_byte, left_speed, right_speed, input ready);
  modport sink   (input valid, action, rx_byte, left_speed, right_speed, output ready);
endinterface
`default_nettype wire

### rtl/wlfe_out_if.sv
// Result channel of the wheel link frame endpoint: valid/ready plus payload.
// Standalone interface, no dependencies.
`default_nettype none
interface wlfe_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         tx_byte;
  logic               last;
  logic               checksum_ok;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic signed [15:0] voltage;
  logic signed [15:0] current;
  logic [7:0]         capacity;

  modport source (output valid, kind, tx_byte, last, checksum_ok, left_count, right_count,
                  voltage, current, capacity, input ready);
  modport sink   (input valid, kind, tx_byte, last, checksum_ok, left_count, right_count,
                  voltage, current, capacity, output ready);
endinterface
`default_nettype wire

### rtl/wlfe_front.sv
// Front end: accepts items, assembles status frames, clamps command speeds.
// Depends on wlfe_pkg and wlfe_in_if; pushes entries into wlfe_queue.
`default_nettype none
module wlfe_front
  import wlfe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  wlfe_in_if.sink     in_ch,
  input  wire cfg_t   cfg,
  input  wire logic   q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic [POS_W-1:0]   rx_position;
  logic [7:0]         rx_sum;
  logic               skip_pending;
  logic [7:0]         frame_bytes [FRAME_LEN];
  logic signed [15:0] held_left, held_right, held_voltage, held_current;
  logic [7:0]         held_capacity;

  logic               accept, rx_take, frame_end, ok;
  logic [POS_W-1:0]   pos;
  logic [7:0]         sum_next;
  logic signed [15:0] new_left, new_right, new_voltage, new_current;
  logic signed [15:0] max_s, l_clamp, r_clamp;

  function automatic logic signed [15:0] clamp16(logic signed [15:0] v,
                                                 logic signed [15:0] m);
    logic signed [15:0] r;
    r = v;
    if (v > m) r = m;
    if (v < -m) r = -m;
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rx_take     = accept && (in_ch.action == ACT_RX) && !skip_pending;
  assign pos         = (rx_position > POS_LAST) ? '0 : rx_position;
  assign sum_next    = rx_sum + in_ch.rx_byte;
  assign frame_end   = rx_take && (pos == POS_LAST);
  assign ok          = (sum_next == 8'd0);

  assign new_left    = {frame_bytes[6],  frame_bytes[7]};
  assign new_right   = {frame_bytes[4],  frame_bytes[5]};
  assign new_voltage = {frame_bytes[12], frame_bytes[13]};
  assign new_current = {frame_bytes[14], frame_bytes[15]};

  assign max_s   = {1'b0, cfg.max_speed};
  assign l_clamp = clamp16(in_ch.left_speed, max_s);
  assign r_clamp = clamp16(in_ch.right_speed, max_s);

  assign q_push = (accept && (in_ch.action == ACT_CMD)) || frame_end;

  always_comb begin
    if (in_ch.action == ACT_CMD) begin
      q_entry = '{kind: KIND_TX, checksum_ok: 1'b0, left: l_clamp, right: r_clamp,
                  voltage: '0, current: '0, capacity: '0};
    end else if (ok) begin
      q_entry = '{kind: KIND_REPORT, checksum_ok: 1'b1, left: new_left, right: new_right,
                  voltage: new_voltage, current: new_current, capacity: frame_bytes[10]};
    end else begin
      q_entry = '{kind: KIND_REPORT, checksum_ok: 1'b0, left: held_left, right: held_right,
                  voltage: held_voltage, current: held_current, capacity: held_capacity};
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      frame_bytes[pos] <= in_ch.rx_byte;
    end
    if (rst) begin
      rx_position   <= '0;
      rx_sum        <= '0;
      skip_pending  <= 1'b0;
      held_left     <= '0;
      held_right    <= '0;
      held_voltage  <= '0;
      held_current  <= '0;
      held_capacity <= '0;
    end else if (accept && (in_ch.action == ACT_RX)) begin
      if (skip_pending) begin
        skip_pending <= 1'b0;
      end else if (pos == POS_LAST) begin
        rx_position <= '0;
        rx_sum      <= '0;
        if (ok) begin
          held_left     <= new_left;
          held_right    <= new_right;
          held_voltage  <= new_voltage;
          held_current  <= new_current;
          held_capacity <= frame_bytes[10];
        end else begin
          skip_pending <= 1'b1;
        end
      end else begin
        rx_position <= pos + 1'b1;
        rx_sum      <= sum_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/wlfe_queue.sv
// Short FIFO of classified entries between the front and back ends.
// Depends on wlfe_pkg for the entry type.
`default_nettype none
module wlfe_queue
  import wlfe_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  entry_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/wlfe_back.sv
// Back end: expands queue entries into results, one per cycle while out_ch is not
// stalled, into an output register. Depends on wlfe_pkg and wlfe_out_if.
`default_nettype none
module wlfe_back
  import wlfe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   q_not_empty,
  input  wire entry_t q_head,
  output logic        q_pop,
  wlfe_out_if.source  out_ch
);

  entry_t               cur;
  logic                 cur_valid;
  logic [CMD_IDX_W-1:0] idx;

  logic       out_free, emit, cur_done;
  logic [7:0] b [7];
  logic [7:0] sum7, cmd_byte;

  assign b[0] = cfg.stop_code;
  assign b[1] = cfg.operation_code;
  assign b[2] = cur.right[15:8];
  assign b[3] = cur.right[7:0];
  assign b[4] = cur.left[15:8];
  assign b[5] = cur.left[7:0];
  assign b[6] = cfg.device_setting;
  assign sum7 = b[0] + b[1] + b[2] + b[3] + b[4] + b[5] + b[6];

  always_comb begin
    case (idx)
      3'd0:    cmd_byte = b[0];
      3'd1:    cmd_byte = b[1];
      3'd2:    cmd_byte = b[2];
      3'd3:    cmd_byte = b[3];
      3'd4:    cmd_byte = b[4];
      3'd5:    cmd_byte = b[5];
      3'd6:    cmd_byte = b[6];
      default: cmd_byte = 8'd0 - sum7;
    endcase
  end

  assign out_free = !out_ch.valid || out_ch.ready;
  assign emit     = out_free && cur_valid;
  assign cur_done = emit && ((cur.kind == KIND_REPORT) || (idx == CMD_IDX_LAST));
  assign q_pop    = q_not_empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (emit) begin
      out_ch.kind <= cur.kind;
      if (cur.kind == KIND_REPORT) begin
        out_ch.tx_byte     <= '0;
        out_ch.last        <= 1'b0;
        out_ch.checksum_ok <= cur.checksum_ok;
        out_ch.left_count  <= cur.left;
        out_ch.right_count <= cur.right;
        out_ch.voltage     <= cur.voltage;
        out_ch.current     <= cur.current;
        out_ch.capacity    <= cur.capacity;
      end else begin
        out_ch.tx_byte     <= cmd_byte;
        out_ch.last        <= (idx == CMD_IDX_LAST);
        out_ch.checksum_ok <= 1'b0;
        out_ch.left_count  <= '0;
        out_ch.right_count <= '0;
        out_ch.voltage     <= '0;
        out_ch.current     <= '0;
        out_ch.capacity    <= '0;
      end
    end
    if (rst) begin
      cur_valid    <= 1'b0;
      idx          <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_free) out_ch.valid <= cur_valid;
      if (q_pop) cur_valid <= 1'b1;
      else if (cur_done) cur_valid <= 1'b0;
      if (cur_done) idx <= '0;
      else if (emit) idx <= idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/wheel_link_frame_endpoint.sv
// Top level of the wheel link frame endpoint: APB register file plus the
// front end, entry queue and back end. Depends on wlfe_pkg, the two channel
// interfaces, wlfe_front, wlfe_queue and wlfe_back.
//
//   channel  dir   handshake       payload
//   in_ch    in    valid/ready     action, rx_byte, left_speed, right_speed
//   out_ch   out   valid/ready     kind, tx_byte, last, checksum_ok, counts,
//                                  voltage, current, capacity
//   apb      in    psel/penable    paddr[3:0], pwdata/prdata 32b, pready = 1
//
// Items go in one per cycle whenever the entry queue has room. On an idle block an
// item's first result passes the queue slot, the back end's current-entry register
// and the output register. The back end issues one result per cycle while the
// output is not stalled; a command gives eight byte results and a report one.
// rst is synchronous and clears all control state and latched values. A stalled
// output holds its register; the input stalls once QUEUE_DEPTH entries wait.
`default_nettype none
module wheel_link_frame_endpoint
  import wlfe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  wlfe_in_if.sink          in_ch,
  wlfe_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic   q_push, q_full, q_pop, q_not_empty;
  entry_t q_in, q_head;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_code      <= 8'd0;
      cfg.operation_code <= 8'd160;
      cfg.device_setting <= 8'd128;
      cfg.max_speed      <= 15'd32767;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STOP:      cfg.stop_code      <= pwdata[7:0];
        REG_OPERATION: cfg.operation_code <= pwdata[7:0];
        REG_DEVICE:    cfg.device_setting <= pwdata[7:0];
        REG_MAX_SPEED: cfg.max_speed      <= pwdata[14:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STOP:      prdata = {24'd0, cfg.stop_code};
      REG_OPERATION: prdata = {24'd0, cfg.operation_code};
      REG_DEVICE:    prdata = {24'd0, cfg.device_setting};
      REG_MAX_SPEED: prdata = {17'd0, cfg.max_speed};
      default:       prdata = '0;
    endcase
  end

  // ---- front end: frame assembly, checksum, latching, speed clamp ----
  wlfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // ---- entry queue decoupling front from back ----
  wlfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // ---- back end: report / command byte emission ----
  wlfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
